@@ src/crc_frame_check_and_mask_core_defines.svh @@
// ---------------------------------------------------------------------------
// CRC frame check and mask core - assertion macros
// Shared property wrappers for the concurrent checks of the core.
// ---------------------------------------------------------------------------
`ifndef CRC_FRAME_CHECK_AND_MASK_CORE_DEFINES_SVH
`define CRC_FRAME_CHECK_AND_MASK_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define CFCM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define CFCM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/cfcm_pkg.sv @@
// ---------------------------------------------------------------------------
// CRC frame check and mask - package
// Types, codes, constants and the byte-wide reflected CRC-32 update.
// ---------------------------------------------------------------------------
package cfcm_pkg;

   localparam int unsigned MAX_LENGTH = 255;

   localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
   localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;
   localparam logic [7:0]  PAD_LIMIT = 8'd252;
   localparam logic [8:0]  POS_MAX   = 9'd511;
   localparam logic [8:0]  MIN_COUNT = 9'd6;
   localparam logic [8:0]  MAX_COUNT = 9'(2 + MAX_LENGTH);

   // Configuration register index (paddr[2])
   localparam logic CSR_IDX_BYTE_MASK = 1'b0;

   typedef enum logic [2:0] {
      KIND_TYPE   = 3'd0,
      KIND_DATA   = 3'd1,
      KIND_PAD    = 3'd2,
      KIND_LENGTH = 3'd3,
      KIND_CRC    = 3'd4,
      KIND_STATUS = 3'd5
   } cfcm_kind_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_TOO_SHORT  = 3'd1,
      ST_TOO_LONG   = 3'd2,
      ST_LEN_MISM   = 3'd3,
      ST_CRC_MISM   = 3'd4,
      ST_CANNOT_PAD = 3'd5
   } cfcm_status_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_HEAD,
      SEQ_PAD,
      SEQ_LENGTH,
      SEQ_CRC,
      SEQ_STATUS
   } cfcm_seq_state_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       frame_end;
   } cfcm_req_type;

   typedef struct packed {
      cfcm_kind_type   item_kind;
      logic [7:0]      item_value;
      cfcm_status_type frame_status;
      logic            last_of_run;
   } cfcm_rsp_type;

   // Everything one input transaction asks of the output sequencer
   typedef struct packed {
      logic            head_valid;
      cfcm_kind_type   head_kind;
      logic [7:0]      head_value;
      logic            frame_done;
      cfcm_status_type status;
      logic [1:0]      pad_count;
      logic [7:0]      new_len;
      logic [31:0]     crc;
   } cfcm_run_type;

   // Reflected CRC-32 over one byte, LSB first
   function automatic logic [31:0] crc_byte(input logic [31:0] crc_cur,
                                            input logic [7:0]  data);
      logic [31:0] c;
      c = crc_cur;
      for (int k = 0; k < 8; k++) begin
         if ((c[0] ^ data[k]) == 1'b1) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

@@ src/cfcm_out_seq.sv @@
// ---------------------------------------------------------------------------
// CRC frame check and mask - output sequencer
// Plays out the result transactions of one input transaction, one per cycle while rsp_stall is low.
// ---------------------------------------------------------------------------
module cfcm_out_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  cfcm_pkg::cfcm_run_type run,
   output logic                 hold,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output cfcm_pkg::cfcm_rsp_type rsp_data
);
   import cfcm_pkg::*;

   cfcm_seq_state_type state_ff, state_in;
   cfcm_run_type       run_ff, run_in;
   logic [1:0]         pad_left_ff, pad_left_in;
   logic [1:0]         crc_idx_ff, crc_idx_in;
   logic [31:0]        crc_ff, crc_in;
   logic [31:0]        crc_final;
   logic               taken;
   logic               run_end;

   // State that follows the head item (or starts a run without one)
   function automatic cfcm_seq_state_type tail_state(input cfcm_run_type r);
      cfcm_seq_state_type s;
      if (!r.frame_done) begin
         s = SEQ_IDLE;
      end else if (r.status != ST_OK) begin
         s = SEQ_STATUS;
      end else if (r.pad_count != 2'd0) begin
         s = SEQ_PAD;
      end else begin
         s = SEQ_LENGTH;
      end
      return s;
   endfunction

   assign crc_final = crc_ff ^ ALL_ONES;
   assign rsp_valid = (state_ff != SEQ_IDLE);
   assign taken     = rsp_valid && !rsp_stall;
   assign run_end   = taken && rsp_data.last_of_run;
   assign hold      = rsp_valid && !run_end;

   // Drive the current result transaction
   always_comb begin
      rsp_data.item_kind    = KIND_STATUS;
      rsp_data.item_value   = 8'd0;
      rsp_data.frame_status = ST_OK;
      rsp_data.last_of_run  = 1'b0;
      case (state_ff)
         SEQ_HEAD: begin
            rsp_data.item_kind   = run_ff.head_kind;
            rsp_data.item_value  = run_ff.head_value;
            rsp_data.last_of_run = !run_ff.frame_done;
         end
         SEQ_PAD: begin
            rsp_data.item_kind = KIND_PAD;
         end
         SEQ_LENGTH: begin
            rsp_data.item_kind  = KIND_LENGTH;
            rsp_data.item_value = run_ff.new_len;
         end
         SEQ_CRC: begin
            rsp_data.item_kind = KIND_CRC;
            case (crc_idx_ff)
               2'd0:    rsp_data.item_value = crc_final[31:24];
               2'd1:    rsp_data.item_value = crc_final[23:16];
               2'd2:    rsp_data.item_value = crc_final[15:8];
               default: rsp_data.item_value = crc_final[7:0];
            endcase
         end
         SEQ_STATUS: begin
            rsp_data.item_kind    = KIND_STATUS;
            rsp_data.frame_status = run_ff.status;
            rsp_data.last_of_run  = 1'b1;
         end
         default: begin
            rsp_data.item_kind = KIND_STATUS;
         end
      endcase
   end

   // Advance through the run, or load the next one
   always_comb begin
      state_in    = state_ff;
      run_in      = run_ff;
      pad_left_in = pad_left_ff;
      crc_idx_in  = crc_idx_ff;
      crc_in      = crc_ff;
      if (!rsp_valid || run_end) begin
         state_in = SEQ_IDLE;
         if (load) begin
            run_in      = run;
            pad_left_in = run.pad_count;
            crc_idx_in  = 2'd0;
            crc_in      = run.crc;
            state_in    = run.head_valid ? SEQ_HEAD : tail_state(run);
         end
      end else if (taken) begin
         case (state_ff)
            SEQ_HEAD: begin
               state_in = tail_state(run_ff);
            end
            SEQ_PAD: begin
               crc_in      = crc_byte(crc_ff, 8'd0);
               pad_left_in = pad_left_ff - 2'd1;
               if (pad_left_ff == 2'd1) begin
                  state_in = SEQ_LENGTH;
               end
            end
            SEQ_LENGTH: begin
               crc_idx_in = 2'd0;
               state_in   = SEQ_CRC;
            end
            SEQ_CRC: begin
               crc_idx_in = crc_idx_ff + 2'd1;
               if (crc_idx_ff == 2'd3) begin
                  state_in = SEQ_STATUS;
               end
            end
            default: begin
               state_in = SEQ_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Run payload holds without reset
   always_ff @(posedge clock) begin
      run_ff      <= run_in;
      pad_left_ff <= pad_left_in;
      crc_idx_ff  <= crc_idx_in;
      crc_ff      <= crc_in;
   end

endmodule

@@ src/crc_frame_check_and_mask_core.sv @@
// ---------------------------------------------------------------------------
// CRC frame check and mask core
// Byte-serial frame checker: masks data, re-computes CRC-32, emits trailer.
// ---------------------------------------------------------------------------
//  Channel | Direction | Handshake            | Payload
//  req_    | in        | req_valid/req_stall  | cfcm_req_type
//  rsp_    | out       | rsp_valid/rsp_stall  | cfcm_rsp_type
//  APB     | in/out    | psel/penable/pready  | byte_mask at offset 0
//
//  A byte yields one result (type, data) or none; a frame-end byte yields a
//  run of up to nine results, one per cycle while rsp_stall is low, set by
//  the output sequencer. Input is stalled while a run is still in flight,
//  except in the cycle its last result is taken. Reset is synchronous and
//  clears the frame state and the mask register to all ones.
// ---------------------------------------------------------------------------
`include "crc_frame_check_and_mask_core_defines.svh"

module crc_frame_check_and_mask_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  cfcm_pkg::cfcm_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output cfcm_pkg::cfcm_rsp_type rsp_data,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [2:0]             paddr,
   input  logic [31:0]            pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);
   import cfcm_pkg::*;

   logic [31:0]     mask_ff;
   logic [8:0]      pos_ff, pos_in;
   logic [7:0]      len_ff, len_in;
   logic [31:0]     orig_crc_ff, orig_crc_in;
   logic [31:0]     mask_crc_ff, mask_crc_in;
   logic [31:0]     rx_crc_ff, rx_crc_in;

   logic            accept;
   logic            seq_hold;
   logic [7:0]      in_byte;
   logic            is_type;
   logic            is_len;
   logic            is_body;
   logic            is_data;
   logic [8:0]      data_off;
   logic [7:0]      data_lim;
   logic [7:0]      mask_sel;
   logic [7:0]      masked_byte;
   logic [8:0]      count;
   cfcm_status_type status;
   logic [1:0]      pad_count;
   cfcm_run_type    run;

   // Configuration port
   assign pready = 1'b1;
   assign prdata = (paddr[2] == CSR_IDX_BYTE_MASK) ? mask_ff : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= ALL_ONES;
      end else if (psel && penable && pwrite && (paddr[2] == CSR_IDX_BYTE_MASK)) begin
         mask_ff <= pwdata;
      end
   end

   // Input handshake
   assign req_stall = seq_hold;
   assign accept    = req_valid && !req_stall;
   assign in_byte   = req_data.frame_byte;

   // Classify the byte by position
   assign is_type  = (pos_ff == 9'd0);
   assign is_len   = (pos_ff == 9'd1);
   assign is_body  = !is_type && !is_len;
   assign data_off = pos_ff - 9'd2;
   assign data_lim = len_ff - 8'd4;
   assign is_data  = is_body && (len_ff >= 8'd4) && (data_off < {1'b0, data_lim});

   // Pick the mask byte for offsets 0..3 of each eight
   always_comb begin
      case ({data_off[2], data_off[1:0]})
         3'b000:  mask_sel = mask_ff[31:24];
         3'b001:  mask_sel = mask_ff[23:16];
         3'b010:  mask_sel = mask_ff[15:8];
         3'b011:  mask_sel = mask_ff[7:0];
         default: mask_sel = 8'hFF;
      endcase
   end
   assign masked_byte = in_byte & mask_sel;

   // Frame state update
   assign len_in      = is_len ? in_byte : len_ff;
   assign orig_crc_in = is_data ? crc_byte(orig_crc_ff, in_byte) : orig_crc_ff;
   assign mask_crc_in = is_data ? crc_byte(mask_crc_ff, masked_byte) : mask_crc_ff;
   assign rx_crc_in   = is_body ? {rx_crc_ff[23:0], in_byte} : rx_crc_ff;
   assign pos_in      = (pos_ff == POS_MAX) ? pos_ff : pos_ff + 9'd1;
   assign count       = pos_in;

   // Frame checks, first failure wins
   always_comb begin
      if (count < MIN_COUNT) begin
         status = ST_TOO_SHORT;
      end else if (count > MAX_COUNT) begin
         status = ST_TOO_LONG;
      end else if ({1'b0, len_in} != (count - 9'd2)) begin
         status = ST_LEN_MISM;
      end else if ((orig_crc_in ^ ALL_ONES) != rx_crc_in) begin
         status = ST_CRC_MISM;
      end else if (len_in > PAD_LIMIT) begin
         status = ST_CANNOT_PAD;
      end else begin
         status = ST_OK;
      end
   end

   // Pad to a multiple of four
   assign pad_count = ~len_in[1:0] + 2'd1;

   // Build the run for the sequencer
   always_comb begin
      run.head_valid = is_type || is_data;
      run.head_kind  = is_type ? KIND_TYPE : KIND_DATA;
      run.head_value = is_type ? in_byte : masked_byte;
      run.frame_done = req_data.frame_end;
      run.status     = status;
      run.pad_count  = pad_count;
      run.new_len    = len_in + {6'd0, pad_count};
      run.crc        = mask_crc_in;
   end

   // Hold frame state; clear it after every frame end
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= 9'd0;
         len_ff      <= 8'd0;
         orig_crc_ff <= ALL_ONES;
         mask_crc_ff <= ALL_ONES;
         rx_crc_ff   <= 32'd0;
      end else if (accept) begin
         if (req_data.frame_end) begin
            pos_ff      <= 9'd0;
            len_ff      <= 8'd0;
            orig_crc_ff <= ALL_ONES;
            mask_crc_ff <= ALL_ONES;
            rx_crc_ff   <= 32'd0;
         end else begin
            pos_ff      <= pos_in;
            len_ff      <= len_in;
            orig_crc_ff <= orig_crc_in;
            mask_crc_ff <= mask_crc_in;
            rx_crc_ff   <= rx_crc_in;
         end
      end
   end

   cfcm_out_seq u_out_seq (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .run       (run),
      .hold      (seq_hold),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Checks
   `CFCM_ASSERT_SAME(a_accept_only_at_run_end, clock, reset,
      (accept && rsp_valid), (rsp_data.last_of_run && !rsp_stall),
      "input taken while a run was still pending")
   `CFCM_ASSERT_SAME(a_status_is_last, clock, reset,
      (rsp_valid && rsp_data.item_kind == KIND_STATUS), (rsp_data.last_of_run),
      "status transaction not marked last")
   `CFCM_ASSERT_SAME(a_status_only_on_status, clock, reset,
      (rsp_valid && rsp_data.item_kind != KIND_STATUS), (rsp_data.frame_status == ST_OK),
      "nonzero status on a byte transaction")
   `CFCM_ASSERT_NEXT(a_pad_then_pad_or_len, clock, reset,
      (rsp_valid && !rsp_stall && rsp_data.item_kind == KIND_PAD),
      (rsp_valid && (rsp_data.item_kind == KIND_PAD || rsp_data.item_kind == KIND_LENGTH)),
      "pad not followed by pad or length")

endmodule

@@ tb/frame_result_checker.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Frame result checker
// Watches the byte, result and register ports of the CRC frame check and mask
// core, predicts the result items of every accepted byte and compares each
// accepted result with the oldest prediction.
// ---------------------------------------------------------------------------
module frame_result_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  cfcm_pkg::cfcm_req_type req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  cfcm_pkg::cfcm_rsp_type rsp_data,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic                   pready,
   input  logic [2:0]             paddr,
   input  logic [31:0]            pwdata,
   output int unsigned            mismatch_count,
   output int unsigned            pending_count,
   output int unsigned            checked_count
);
   import cfcm_pkg::*;

   // Shadow of the mask register and of the frame state
   logic [31:0] mask_reg;
   logic [8:0]  byte_pos;
   logic [7:0]  len_field;
   logic [31:0] orig_crc;
   logic [31:0] masked_crc;
   logic [31:0] rx_crc;

   cfcm_rsp_type expected_items[$];

   // Reflected CRC-32, one byte folded in at the low end
   function automatic logic [31:0] crc32_update(input logic [31:0] crc,
                                                input logic [7:0]  b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   task automatic clear_frame();
      byte_pos   = 9'd0;
      len_field  = 8'd0;
      orig_crc   = ALL_ONES;
      masked_crc = ALL_ONES;
      rx_crc     = 32'd0;
   endtask

   task automatic push_item(input cfcm_kind_type kind, input logic [7:0] value,
                            input cfcm_status_type status);
      cfcm_rsp_type item;
      item.item_kind    = kind;
      item.item_value   = value;
      item.frame_status = status;
      item.last_of_run  = 1'b0;
      expected_items.push_back(item);
   endtask

   // Work out every result one frame byte causes
   task automatic predict_frame_byte(input cfcm_req_type item);
      logic [8:0]      off;
      logic [8:0]      count;
      logic [7:0]      mask_pick;
      logic [7:0]      masked;
      logic [7:0]      pad_len;
      logic [31:0]     trailer_crc;
      cfcm_status_type verdict;
      cfcm_rsp_type    tail;
      int              n0;
      n0 = expected_items.size();
      if (byte_pos == 9'd0) begin
         push_item(KIND_TYPE, item.frame_byte, ST_OK);
      end else if (byte_pos == 9'd1) begin
         len_field = item.frame_byte;
      end else begin
         off = byte_pos - 9'd2;
         // Mask offsets 0..3 of each group of eight, pass 4..7
         if (len_field >= 8'd4 && off < {1'b0, len_field} - 9'd4) begin
            mask_pick  = (off[2] == 1'b0) ? mask_reg[31 - 8 * off[1:0] -: 8] : 8'hFF;
            masked     = item.frame_byte & mask_pick;
            orig_crc   = crc32_update(orig_crc, item.frame_byte);
            masked_crc = crc32_update(masked_crc, masked);
            push_item(KIND_DATA, masked, ST_OK);
         end
         rx_crc = {rx_crc[23:0], item.frame_byte};
      end
      if (byte_pos != POS_MAX) begin
         byte_pos = byte_pos + 9'd1;
      end

      // Check the frame at its end; first failing check wins
      if (item.frame_end) begin
         count = byte_pos;
         if (count < MIN_COUNT) begin
            verdict = ST_TOO_SHORT;
         end else if (count > MAX_COUNT) begin
            verdict = ST_TOO_LONG;
         end else if ({1'b0, len_field} != count - 9'd2) begin
            verdict = ST_LEN_MISM;
         end else if ((orig_crc ^ ALL_ONES) != rx_crc) begin
            verdict = ST_CRC_MISM;
         end else if (len_field > PAD_LIMIT) begin
            verdict = ST_CANNOT_PAD;
         end else begin
            verdict = ST_OK;
         end
         if (verdict == ST_OK) begin
            pad_len     = len_field;
            trailer_crc = masked_crc;
            while (pad_len[1:0] != 2'b00) begin
               trailer_crc = crc32_update(trailer_crc, 8'h00);
               push_item(KIND_PAD, 8'h00, ST_OK);
               pad_len = pad_len + 8'd1;
            end
            trailer_crc = trailer_crc ^ ALL_ONES;
            push_item(KIND_LENGTH, pad_len, ST_OK);
            for (int i = 3; i >= 0; i--) begin
               push_item(KIND_CRC, trailer_crc[8 * i +: 8], ST_OK);
            end
         end
         push_item(KIND_STATUS, 8'h00, verdict);
         clear_frame();
      end

      // Flag the final result of this byte
      if (expected_items.size() > n0) begin
         tail = expected_items.pop_back();
         tail.last_of_run = 1'b1;
         expected_items.push_back(tail);
      end
   endtask

   // Track register writes, predict on input, compare on output
   always @(posedge clock) begin
      cfcm_rsp_type want;
      if (reset) begin
         mask_reg = ALL_ONES;
         clear_frame();
         expected_items.delete();
         mismatch_count = 0;
         checked_count  = 0;
      end else begin
         if (psel && penable && pwrite && pready && paddr == {CSR_IDX_BYTE_MASK, 2'b00}) begin
            mask_reg = pwdata;
         end
         if (req_valid && !req_stall) begin
            predict_frame_byte(req_data);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_items.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected result: expected none,", $time,
                        " actual kind=%0d value=%02h status=%0d last=%0b",
                        rsp_data.item_kind, rsp_data.item_value,
                        rsp_data.frame_status, rsp_data.last_of_run);
            end else begin
               want = expected_items.pop_front();
               checked_count++;
               if (rsp_data.item_kind !== want.item_kind ||
                   rsp_data.item_value !== want.item_value ||
                   rsp_data.frame_status !== want.frame_status ||
                   rsp_data.last_of_run !== want.last_of_run) begin
                  mismatch_count++;
                  $display("%0t: mismatch: expected kind=%0d value=%02h status=%0d last=%0b,",
                           $time, want.item_kind, want.item_value, want.frame_status,
                           want.last_of_run,
                           " actual kind=%0d value=%02h status=%0d last=%0b",
                           rsp_data.item_kind, rsp_data.item_value,
                           rsp_data.frame_status, rsp_data.last_of_run);
               end
            end
         end
      end
      pending_count = expected_items.size();
   end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// CRC frame check and mask core - testbench
// Drives directed and random frames through the core under several mask
// settings with random idling on both channels and one long output hold;
// a separate checker predicts and compares every result.
// ---------------------------------------------------------------------------
module testbench;
   import cfcm_pkg::*;

   localparam int HOLD_CYCLES = 150;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   cfcm_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   cfcm_rsp_type rsp_data;
   logic         psel = 1'b0;
   logic         penable = 1'b0;
   logic         pwrite = 1'b0;
   logic [2:0]   paddr = '0;
   logic [31:0]  pwdata = '0;
   logic [31:0]  prdata;
   logic         pready;

   int unsigned mismatch_count;
   int unsigned pending_count;
   int unsigned checked_count;

   bit sender_gaps_on   = 1'b0;
   bit receiver_gaps_on = 1'b0;
   bit long_hold_req    = 1'b0;

   int unsigned bytes_sent  = 0;
   int unsigned frames_sent = 0;

   logic [7:0] payload[$];
   logic [7:0] frame_buf[$];

   crc_frame_check_and_mask_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   frame_result_checker u_result_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .pready         (pready),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .checked_count  (checked_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Hard limit on run time
   initial begin
      #10_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // Result side: random stall bursts, and one long hold on request
   initial begin
      int n;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_stall <= 1'b0;
            long_hold_req = 1'b0;
         end else if (receiver_gaps_on && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            n = $urandom_range(1, 9);
            repeat (n) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic logic [31:0] crc32_next(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   task automatic fill_random_payload(input int ndata);
      payload.delete();
      repeat (ndata) payload.push_back(8'($urandom_range(0, 255)));
   endtask

   // Type, length, payload, then the big-endian CRC of the payload
   task automatic build_good_frame(input logic [7:0] ftype);
      logic [31:0] crc;
      crc = ALL_ONES;
      frame_buf.delete();
      frame_buf.push_back(ftype);
      frame_buf.push_back(8'(payload.size() + 4));
      foreach (payload[i]) begin
         frame_buf.push_back(payload[i]);
         crc = crc32_next(crc, payload[i]);
      end
      crc = crc ^ ALL_ONES;
      for (int i = 3; i >= 0; i--) frame_buf.push_back(crc[8 * i +: 8]);
   endtask

   // Offer one byte, with an optional idle burst ahead of it; hold until taken
   task automatic send_frame_byte(input logic [7:0] b, input logic e);
      cfcm_req_type item;
      int           gap;
      gap = 0;
      if (sender_gaps_on && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 9);
      item.frame_byte = b;
      item.frame_end  = e;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   task automatic send_frame();
      foreach (frame_buf[i]) send_frame_byte(frame_buf[i], i == frame_buf.size() - 1);
      frames_sent++;
   endtask

   // Drop valid and let every pending result come out
   task automatic wait_until_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (16) @(negedge clock);
   endtask

   task automatic write_byte_mask(input logic [31:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {CSR_IDX_BYTE_MASK, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Mostly well-formed frames, the rest broken frames and noise
   task automatic run_random_frames(input int unsigned budget, input bit gaps_allowed);
      int unsigned start;
      int          pick;
      int          idx;
      start = bytes_sent;
      while (bytes_sent - start < budget) begin
         sender_gaps_on   = gaps_allowed && ($urandom_range(0, 3) != 0);
         receiver_gaps_on = gaps_allowed && ($urandom_range(0, 3) != 0);
         pick = $urandom_range(0, 15);
         fill_random_payload($urandom_range(0, 40));
         build_good_frame(8'($urandom_range(0, 255)));
         case (pick)
            10: begin
               // corrupt one CRC bit
               idx = frame_buf.size() - 1 - $urandom_range(0, 3);
               frame_buf[idx] = frame_buf[idx] ^ 8'(1 << $urandom_range(0, 7));
            end
            11: begin
               frame_buf[1] = frame_buf[1] + 8'($urandom_range(1, 255));
            end
            12: begin
               // drop or add one trailing byte
               if ($urandom_range(0, 1) == 0) void'(frame_buf.pop_back());
               else frame_buf.push_back(8'($urandom_range(0, 255)));
            end
            13: begin
               // length field below four
               frame_buf.delete();
               frame_buf.push_back(8'($urandom_range(0, 255)));
               frame_buf.push_back(8'($urandom_range(0, 3)));
               repeat ($urandom_range(0, 8)) frame_buf.push_back(8'($urandom_range(0, 255)));
            end
            14, 15: begin
               // short frames and noise
               frame_buf.delete();
               repeat ($urandom_range(1, (pick == 14) ? 5 : 12)) begin
                  frame_buf.push_back(8'($urandom_range(0, 255)));
               end
            end
            default: ;
         endcase
         send_frame();
      end
   endtask

   // Stimulus and verdict
   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed frames under the reset mask
      sender_gaps_on   = 1'b1;
      receiver_gaps_on = 1'b1;
      payload.delete();
      build_good_frame(8'h00);
      send_frame();
      frame_buf = {8'hFF};
      send_frame();
      frame_buf = {8'h5A, 8'hFF};
      send_frame();
      payload = {8'hFF, 8'h00, 8'h80, 8'h01, 8'h7F};
      build_good_frame(8'hA5);
      send_frame();
      payload.delete();
      build_good_frame(8'h3C);
      frame_buf[5] = frame_buf[5] ^ 8'h01;
      send_frame();
      wait_until_idle();

      write_byte_mask(32'h0000_0000);
      run_random_frames(20, 1'b1);
      wait_until_idle();

      // Overlong frame with full-length data, and a long hold on the result side
      write_byte_mask($urandom);
      sender_gaps_on   = 1'b1;
      receiver_gaps_on = 1'b1;
      long_hold_req    = 1'b1;
      frame_buf.delete();
      repeat (259) frame_buf.push_back(8'($urandom_range(0, 255)));
      frame_buf[1] = 8'hFF;
      send_frame();
      wait_until_idle();

      write_byte_mask($urandom);
      run_random_frames(15, 1'b1);
      wait_until_idle();

      // Last part: no idling on either side
      write_byte_mask(32'hFFFF_FFFF);
      run_random_frames(20, 1'b0);
      wait_until_idle();

      $display("Sent %0d frames (%0d bytes) under reset, zero, random and all-ones masks;",
               frames_sent, bytes_sent);
      $display("checked %0d results, including a %0d-cycle output hold.", checked_count,
               HOLD_CYCLES);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
